// ===== rtl/gsat_pkg.sv =====
// Shared types, constants and tables for the gated sine alarm tone unit.
package gsat_pkg;

    localparam int RATE_W    = 17;
    localparam int SAMPLE_W  = 15;
    localparam int CFG_IDX_W = 2;
    localparam int CAD_W     = 10;
    localparam int QT_W      = 32;
    localparam int PROD_W    = 64;
    localparam int SUM_W     = 34;
    localparam int MAG_W     = 14;
    localparam int SEL_W     = 4;
    localparam int SER_N     = 14;

    localparam int PHASE_STEPS_DEF = 4096;

    localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO = 2'd1;

    localparam logic CMD_GEN    = 1'b0;
    localparam logic CMD_REWIND = 1'b1;

    localparam logic [RATE_W-1:0] RATE_MIN   = 17'd8000;
    localparam logic [RATE_W-1:0] RATE_MAX   = 17'd96000;
    localparam logic [RATE_W-1:0] RATE_RESET = 17'd16000;
    localparam logic [RATE_W-1:0] BEEP_HZ    = 17'd880;
    localparam logic [RATE_W-1:0] MS_PER_S   = 17'd1000;
    localparam logic [CAD_W-1:0]  ON_MS      = 10'd400;
    localparam logic [CAD_W-1:0]  CYCLE_LAST = 10'd699;
    localparam logic [CAD_W-1:0]  CYCLE_MS   = 10'd700;

    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [31:0] Q30_ONE     = 32'h4000_0000;
    localparam logic [31:0] PEAK        = 32'd10000;
    localparam int          SER_TERMS   = 7;

    // series divisors: sine terms first, then cosine terms
    localparam logic [7:0] SER_DIV [SER_N] = '{
        8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210,
        8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132, 8'd182
    };

    localparam logic [63:0] TWO_32 = 64'h1_0000_0000;

    // floor(2^32 / divisor); quotient estimate is low by at most one
    localparam logic [31:0] SER_RECIP [SER_N] = '{
        32'(TWO_32 / 64'd6),   32'(TWO_32 / 64'd20),  32'(TWO_32 / 64'd42),
        32'(TWO_32 / 64'd72),  32'(TWO_32 / 64'd110), 32'(TWO_32 / 64'd156),
        32'(TWO_32 / 64'd210), 32'(TWO_32 / 64'd2),   32'(TWO_32 / 64'd12),
        32'(TWO_32 / 64'd30),  32'(TWO_32 / 64'd56),  32'(TWO_32 / 64'd90),
        32'(TWO_32 / 64'd132), 32'(TWO_32 / 64'd182)
    };

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_K_MUL,
        ST_K_LOAD,
        ST_DIV_K,
        ST_F_LOAD,
        ST_FR_MUL,
        ST_FC_MUL,
        ST_FI_MUL,
        ST_F_SUM,
        ST_X_MUL,
        ST_X2_MUL,
        ST_SER_INIT,
        ST_T_MUL,
        ST_R_MUL,
        ST_C_MUL,
        ST_UPD,
        ST_M_MUL,
        ST_SAMPLE,
        ST_FINISH
    } gsat_state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_REWIND,
        OP_START,
        OP_K_MUL,
        OP_K_LOAD,
        OP_DIV_K,
        OP_F_LOAD,
        OP_FR_MUL,
        OP_FC_MUL,
        OP_FI_MUL,
        OP_F_SUM,
        OP_X_MUL,
        OP_X2_MUL,
        OP_SER_INIT,
        OP_T_MUL,
        OP_R_MUL,
        OP_C_MUL,
        OP_UPD,
        OP_M_MUL,
        OP_SAMPLE,
        OP_FINISH
    } gsat_op_t;

    typedef struct packed {
        gsat_op_t         op;
        logic [SEL_W-1:0] div_sel;
        logic             sub;
    } gsat_cmd_t;

    typedef struct packed {
        logic sounding;
        logic cosine;
        logic out_free;
    } gsat_stat_t;

endpackage

// ===== rtl/gsat_req_if.sv =====
// Frame request channel: command and last-frame flag.
interface gsat_req_if;
    import gsat_pkg::*;

    logic valid;
    logic ready;
    logic command;
    logic last_frame;

    modport source (output valid, output command, output last_frame, input ready);
    modport sink (input valid, input command, input last_frame, output ready);
endinterface

// ===== rtl/gsat_frame_if.sv =====
// Output frame channel: left and right samples, tone flag, last flag.
interface gsat_frame_if;
    import gsat_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       tone_on;
    logic                       last;

    modport source (output valid, output left_sample, output right_sample,
                    output tone_on, output last, input ready);
    modport sink (input valid, input left_sample, input right_sample,
                  input tone_on, input last, output ready);
endinterface

// ===== rtl/gsat_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface gsat_cfg_if;
    import gsat_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [RATE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/gsat_ctrl.sv =====
// Sequencer for the tone unit: divider steps, series loop and frame handoff.
module gsat_ctrl #(
    parameter int PHASE_STEPS = gsat_pkg::PHASE_STEPS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_command,
    output logic                req_ready,
    input  gsat_pkg::gsat_stat_t stat,
    output gsat_pkg::gsat_cmd_t  cmd
);
    import gsat_pkg::*;

    localparam int KW      = $clog2(PHASE_STEPS);
    localparam bit PS_POW2 = (PHASE_STEPS & (PHASE_STEPS - 1)) == 0;
    localparam int CNT_W   = 6;
    localparam logic [CNT_W-1:0] K_LAST   = CNT_W'(KW - 1);
    localparam logic [CNT_W-1:0] SER_LAST = CNT_W'(SER_TERMS);

    gsat_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && req_command == CMD_GEN)
                begin
                    state_next = stat.sounding ? ST_K_MUL : ST_FINISH;
                end
            end
            ST_K_MUL:
            begin
                state_next = ST_K_LOAD;
            end
            ST_K_LOAD:
            begin
                state_next = ST_DIV_K;
                cnt_next   = '0;
            end
            ST_DIV_K:
            begin
                if (cnt_reg == K_LAST)
                begin
                    state_next = ST_F_LOAD;
                end
                cnt_next = cnt_reg + 1'b1;
            end
            ST_F_LOAD:
            begin
                state_next = PS_POW2 ? ST_X_MUL : ST_FR_MUL;
            end
            ST_FR_MUL:
            begin
                state_next = ST_FC_MUL;
            end
            ST_FC_MUL:
            begin
                state_next = ST_FI_MUL;
            end
            ST_FI_MUL:
            begin
                state_next = ST_F_SUM;
            end
            ST_F_SUM:
            begin
                state_next = ST_X_MUL;
            end
            ST_X_MUL:
            begin
                state_next = ST_X2_MUL;
            end
            ST_X2_MUL:
            begin
                state_next = ST_SER_INIT;
            end
            ST_SER_INIT:
            begin
                state_next = ST_T_MUL;
                cnt_next   = CNT_W'(1);
            end
            ST_T_MUL:
            begin
                state_next = ST_R_MUL;
            end
            ST_R_MUL:
            begin
                state_next = ST_C_MUL;
            end
            ST_C_MUL:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (cnt_reg == SER_LAST)
                begin
                    state_next = ST_M_MUL;
                end
                else
                begin
                    state_next = ST_T_MUL;
                    cnt_next   = cnt_reg + 1'b1;
                end
            end
            ST_M_MUL:
            begin
                state_next = ST_SAMPLE;
            end
            ST_SAMPLE:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready   = 1'b0;
        cmd.op      = OP_NONE;
        cmd.sub     = cnt_reg[0];
        cmd.div_sel = stat.cosine ? SEL_W'(cnt_reg[SEL_W-1:0] + 4'd6)
                                  : SEL_W'(cnt_reg[SEL_W-1:0] - 4'd1);
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.op = (req_command == CMD_REWIND) ? OP_REWIND : OP_START;
                end
            end
            ST_K_MUL:    cmd.op = OP_K_MUL;
            ST_K_LOAD:   cmd.op = OP_K_LOAD;
            ST_DIV_K:    cmd.op = OP_DIV_K;
            ST_F_LOAD:   cmd.op = OP_F_LOAD;
            ST_FR_MUL:   cmd.op = OP_FR_MUL;
            ST_FC_MUL:   cmd.op = OP_FC_MUL;
            ST_FI_MUL:   cmd.op = OP_FI_MUL;
            ST_F_SUM:    cmd.op = OP_F_SUM;
            ST_X_MUL:    cmd.op = OP_X_MUL;
            ST_X2_MUL:   cmd.op = OP_X2_MUL;
            ST_SER_INIT: cmd.op = OP_SER_INIT;
            ST_T_MUL:    cmd.op = OP_T_MUL;
            ST_R_MUL:    cmd.op = OP_R_MUL;
            ST_C_MUL:    cmd.op = OP_C_MUL;
            ST_UPD:      cmd.op = OP_UPD;
            ST_M_MUL:    cmd.op = OP_M_MUL;
            ST_SAMPLE:   cmd.op = OP_SAMPLE;
            ST_FINISH:   cmd.op = stat.out_free ? OP_FINISH : OP_NONE;
            default:     cmd.op = OP_NONE;
        endcase
    end

endmodule

// ===== rtl/gsat_dp.sv =====
// Datapath: registers, position counters, shared multiplier, divider and output stage.
module gsat_dp #(
    parameter int PHASE_STEPS = gsat_pkg::PHASE_STEPS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  gsat_pkg::gsat_cmd_t                   cmd,
    output gsat_pkg::gsat_stat_t                  stat,
    input  logic                                  req_last,
    input  logic                                  cfg_valid,
    input  logic [gsat_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [gsat_pkg::RATE_W-1:0]           cfg_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [gsat_pkg::SAMPLE_W-1:0]  out_left,
    output logic signed [gsat_pkg::SAMPLE_W-1:0]  out_right,
    output logic                                  out_tone,
    output logic                                  out_last
);
    import gsat_pkg::*;

    localparam int KW      = $clog2(PHASE_STEPS);
    localparam bit PS_POW2 = (PHASE_STEPS & (PHASE_STEPS - 1)) == 0;
    // f = k * PS_RECIP + floor(k * PS_REM / PHASE_STEPS)
    localparam logic [31:0] PS_RECIP = 32'(TWO_32 / 64'(PHASE_STEPS));
    localparam logic [31:0] PS_REM   = 32'(TWO_32 % 64'(PHASE_STEPS));

    // configuration
    logic [RATE_W-1:0] rate_eff_reg;
    logic              stereo_reg;
    logic [RATE_W-1:0] rate_clamp;
    logic              cfg_hit;

    // frame position
    logic [CAD_W-1:0]  cad_reg;
    logic [RATE_W-1:0] msr_reg;
    logic [RATE_W-1:0] ph_reg;
    logic [RATE_W:0]   msr_sum;
    logic [RATE_W:0]   ph_sum;
    logic              msr_wrap;
    logic              ph_wrap;

    // divider
    logic [RATE_W-1:0] rem_reg;
    logic [QT_W-1:0]   low_reg;
    logic [QT_W-1:0]   qt_reg;
    logic [RATE_W:0]   rem_shift;
    logic [RATE_W-1:0] divisor;
    logic              div_ge;
    logic [KW-1:0]     k_val;
    logic [31:0]       f_rem;
    logic [31:0]       f_fix;

    // multiplier and series
    logic [31:0]       mul_a;
    logic [31:0]       mul_b;
    logic [PROD_W-1:0] prod_next;
    logic [PROD_W-1:0] prod_reg;
    logic [30:0]       x_reg;
    logic [31:0]       x2_reg;
    logic [31:0]       term_reg;
    logic [31:0]       v_reg;
    logic [31:0]       q0_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [31:0]       rem_c;
    logic [31:0]       q_fix;
    logic [30:0]       s_clamp;
    logic [MAG_W-1:0]  mag;
    logic [SAMPLE_W-1:0] mag_ext;
    logic [SAMPLE_W-1:0] sample_reg;
    logic              last_reg;

    // output stage
    logic              out_full_reg;
    logic [SAMPLE_W-1:0] left_reg;
    logic [SAMPLE_W-1:0] right_reg;
    logic              tone_reg;
    logic              olast_reg;

    assign rate_clamp = (cfg_data < RATE_MIN) ? RATE_MIN :
                        (cfg_data > RATE_MAX) ? RATE_MAX : cfg_data;
    assign cfg_hit    = cfg_valid && (cfg_index == CFG_RATE || cfg_index == CFG_STEREO);

    assign msr_sum  = {1'b0, msr_reg} + {1'b0, MS_PER_S};
    assign ph_sum   = {1'b0, ph_reg} + {1'b0, BEEP_HZ};
    assign msr_wrap = msr_sum >= {1'b0, rate_eff_reg};
    assign ph_wrap  = ph_sum >= {1'b0, rate_eff_reg};

    assign k_val     = qt_reg[KW-1:0];
    assign divisor   = rate_eff_reg;
    assign rem_shift = {rem_reg, low_reg[QT_W-1]};
    assign div_ge    = rem_shift >= {1'b0, divisor};

    assign f_rem = v_reg - prod_reg[31:0];
    assign f_fix = (f_rem >= 32'(PHASE_STEPS)) ? q0_reg + 32'd1 : q0_reg;

    assign rem_c = v_reg - prod_reg[31:0];
    assign q_fix = (rem_c >= {24'd0, SER_DIV[cmd.div_sel]}) ? q0_reg + 32'd1 : q0_reg;

    always_comb
    begin
        if (sum_reg[SUM_W-1])
        begin
            s_clamp = '0;
        end
        else if (sum_reg > $signed({2'b00, Q30_ONE}))
        begin
            s_clamp = Q30_ONE[30:0];
        end
        else
        begin
            s_clamp = sum_reg[30:0];
        end
    end

    assign mag     = prod_reg[30 +: MAG_W];
    assign mag_ext = {1'b0, mag};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_K_MUL:
            begin
                mul_a = 32'(ph_reg);
                mul_b = 32'(PHASE_STEPS);
            end
            OP_F_LOAD:
            begin
                mul_a = 32'(k_val);
                mul_b = PS_REM;
            end
            OP_FR_MUL:
            begin
                mul_a = prod_reg[31:0];
                mul_b = PS_RECIP;
            end
            OP_FC_MUL:
            begin
                mul_a = prod_reg[63:32];
                mul_b = 32'(PHASE_STEPS);
            end
            OP_FI_MUL:
            begin
                mul_a = 32'(k_val);
                mul_b = PS_RECIP;
            end
            OP_X_MUL:
            begin
                mul_a = {2'b00, qt_reg[29:0]};
                mul_b = HALF_PI_Q30;
            end
            OP_X2_MUL:
            begin
                mul_a = {1'b0, prod_reg[60:30]};
                mul_b = {1'b0, prod_reg[60:30]};
            end
            OP_T_MUL:
            begin
                mul_a = term_reg;
                mul_b = x2_reg;
            end
            OP_R_MUL:
            begin
                mul_a = prod_reg[61:30];
                mul_b = SER_RECIP[cmd.div_sel];
            end
            OP_C_MUL:
            begin
                mul_a = prod_reg[63:32];
                mul_b = {24'd0, SER_DIV[cmd.div_sel]};
            end
            OP_M_MUL:
            begin
                mul_a = {1'b0, s_clamp};
                mul_b = PEAK;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = {32'd0, mul_a} * {32'd0, mul_b};

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_eff_reg <= RATE_RESET;
            stereo_reg   <= 1'b1;
            cad_reg      <= '0;
            msr_reg      <= '0;
            ph_reg       <= '0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == CFG_RATE)
            begin
                rate_eff_reg <= rate_clamp;
            end
            if (cfg_valid && cfg_index == CFG_STEREO)
            begin
                stereo_reg <= cfg_data[0];
            end

            if (cfg_hit || cmd.op == OP_REWIND)
            begin
                cad_reg <= '0;
                msr_reg <= '0;
                ph_reg  <= '0;
            end
            else if (cmd.op == OP_FINISH)
            begin
                msr_reg <= msr_wrap ? RATE_W'(msr_sum - {1'b0, rate_eff_reg})
                                    : msr_sum[RATE_W-1:0];
                if (msr_wrap)
                begin
                    cad_reg <= (cad_reg == CYCLE_LAST) ? '0 : cad_reg + 1'b1;
                end
                ph_reg <= ph_wrap ? RATE_W'(ph_sum - {1'b0, rate_eff_reg})
                                  : ph_sum[RATE_W-1:0];
            end

            if (cmd.op == OP_FINISH)
            begin
                out_full_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_full_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_START:
            begin
                sample_reg <= '0;
                last_reg   <= req_last;
            end
            OP_K_LOAD:
            begin
                rem_reg <= prod_reg[KW +: RATE_W];
                low_reg <= QT_W'(prod_reg[KW-1:0]) << (QT_W - KW);
                qt_reg  <= '0;
            end
            OP_DIV_K:
            begin
                rem_reg <= div_ge ? RATE_W'(rem_shift - {1'b0, divisor})
                                  : rem_shift[RATE_W-1:0];
                low_reg <= {low_reg[QT_W-2:0], 1'b0};
                qt_reg  <= {qt_reg[QT_W-2:0], div_ge};
            end
            OP_F_LOAD:
            begin
                if (PS_POW2)
                begin
                    qt_reg <= QT_W'(k_val) << (QT_W - KW);
                end
            end
            OP_FR_MUL:
            begin
                v_reg <= prod_reg[31:0];
            end
            OP_FC_MUL:
            begin
                q0_reg <= prod_reg[63:32];
            end
            OP_FI_MUL:
            begin
                low_reg <= f_fix;
            end
            OP_F_SUM:
            begin
                qt_reg <= prod_reg[31:0] + low_reg;
            end
            OP_X2_MUL:
            begin
                x_reg <= prod_reg[60:30];
            end
            OP_SER_INIT:
            begin
                x2_reg   <= prod_reg[61:30];
                term_reg <= qt_reg[30] ? Q30_ONE : {1'b0, x_reg};
                sum_reg  <= qt_reg[30] ? $signed({2'b00, Q30_ONE})
                                       : $signed({3'b000, x_reg});
            end
            OP_R_MUL:
            begin
                v_reg <= prod_reg[61:30];
            end
            OP_C_MUL:
            begin
                q0_reg <= prod_reg[63:32];
            end
            OP_UPD:
            begin
                term_reg <= q_fix;
                sum_reg  <= cmd.sub ? sum_reg - $signed({2'b00, q_fix})
                                    : sum_reg + $signed({2'b00, q_fix});
            end
            OP_SAMPLE:
            begin
                sample_reg <= qt_reg[31] ? SAMPLE_W'(-mag_ext) : mag_ext;
            end
            OP_FINISH:
            begin
                left_reg  <= sample_reg;
                right_reg <= stereo_reg ? sample_reg : '0;
                tone_reg  <= cad_reg < ON_MS;
                olast_reg <= last_reg;
            end
            default:
            begin
            end
        endcase

        case (cmd.op)
            OP_K_MUL, OP_F_LOAD, OP_FR_MUL, OP_FC_MUL, OP_FI_MUL, OP_X_MUL, OP_X2_MUL,
            OP_T_MUL, OP_R_MUL, OP_C_MUL, OP_M_MUL:
            begin
                prod_reg <= prod_next;
            end
            default:
            begin
            end
        endcase
    end

    assign stat.sounding = cad_reg < ON_MS;
    assign stat.cosine   = qt_reg[30];
    assign stat.out_free = !out_full_reg || out_ready;

    assign out_valid = out_full_reg;
    assign out_left  = left_reg;
    assign out_right = right_reg;
    assign out_tone  = tone_reg;
    assign out_last  = olast_reg;

    a_cadence_range: assert property (@(posedge clk) disable iff (!rst_n)
        cad_reg < CYCLE_MS)
        else $error("cadence counter out of cycle");

    a_position_below_rate: assert property (@(posedge clk) disable iff (!rst_n)
        msr_reg < rate_eff_reg && ph_reg < rate_eff_reg)
        else $error("position remainder not below rate");

    a_rate_range: assert property (@(posedge clk) disable iff (!rst_n)
        rate_eff_reg >= RATE_MIN && rate_eff_reg <= RATE_MAX)
        else $error("effective rate out of range");

    a_phase_index: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_F_LOAD |-> 32'(k_val) < 32'(PHASE_STEPS))
        else $error("phase index not below phase steps");

    a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_SAMPLE |=>
        ($signed(sample_reg) <= 15'sd10000 && $signed(sample_reg) >= -15'sd10000))
        else $error("sample magnitude above peak");

endmodule

// ===== rtl/gated_sine_alarm_tone_unit.sv =====
// Top level of the gated sine alarm tone unit.
// Each generate beat on req yields one frame on frame: an 880 Hz sine of peak 10000,
// gated 400 ms on and 300 ms off, timed from the frame count since the last rewind at
// the programmed sample rate (clamped to 8000..96000). A rewind beat, or any write to
// register 0 (rate) or 1 (stereo), restarts the count and gives no frame. The phase
// divider gives one quotient bit per cycle, and the sine series, which adds seven
// terms after the first, runs through one shared 32x32 multiplier. A finished frame
// waits in the output register while the next request is taken; cfg is always ready.
module gated_sine_alarm_tone_unit #(
    parameter int PHASE_STEPS = gsat_pkg::PHASE_STEPS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    gsat_req_if.sink     req,
    gsat_frame_if.source frame,
    gsat_cfg_if.sink     cfg
);
    import gsat_pkg::*;

    gsat_cmd_t  cmd;
    gsat_stat_t stat;

    assign cfg.ready = 1'b1;

    gsat_ctrl #(
        .PHASE_STEPS (PHASE_STEPS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_command (req.command),
        .req_ready   (req.ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    gsat_dp #(
        .PHASE_STEPS (PHASE_STEPS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .req_last  (req.last_frame),
        .cfg_valid (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .out_valid (frame.valid),
        .out_ready (frame.ready),
        .out_left  (frame.left_sample),
        .out_right (frame.right_sample),
        .out_tone  (frame.tone_on),
        .out_last  (frame.last)
    );

endmodule
